// ----- sv/qso_pkg.sv -----
// Shared types and constants of the quadrature speed odometer.
package qso_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int SPEED_BITS_DEF = 16;

  localparam int MS_PER_S  = 1000;
  localparam int MS_BITS   = $clog2(MS_PER_S);
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_PER_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD_MS = CFG_IDX_W'(1);

  localparam logic [15:0] PERIOD_RESET = 16'd10;

  typedef enum logic [1:0] {
    FN_EDGE  = 2'd0,
    FN_TICK  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_PUT
  } top_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_PREP,
    U_MUL,
    U_DSET,
    U_DIV,
    U_DONE
  } unit_state_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] velocity;
  } tick_res_t;

endpackage

// ----- sv/qso_ifs.sv -----
// Handshake channel interfaces of the quadrature speed odometer.
interface qso_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       phase_a;
  logic       phase_b;

  modport source (output valid, func, phase_a, phase_b, input ready);
  modport sink   (input valid, func, phase_a, phase_b, output ready);
endinterface

interface qso_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [15:0] pulse_speed;
  logic signed [31:0] velocity;
  logic               velocity_saturated;
  logic signed [63:0] distance;

  modport source (output valid, position, pulse_speed, velocity, velocity_saturated, distance,
                  input ready);
  modport sink   (input valid, position, pulse_speed, velocity, velocity_saturated, distance,
                  output ready);
endinterface

interface qso_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [qso_pkg::CFG_IDX_W-1:0]  index;
  logic [qso_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/quadrature_speed_odometer_top.sv -----
// Top level of the quadrature speed odometer: event handling, state and result register.
// Edge, clear and unused events: the result goes through ST_PUT into the output register.
// Sample tick: the result waits in ST_WAIT for the speed unit, then goes through ST_PUT;
// the unit runs the bit-serial multiply (SPEED_BITS + 10 steps) and the 32-step restoring divide.
// A new event is taken once the previous result sits in the output register.
// Synchronous active-low reset zeroes all counts and totals; configuration registers reset to 0 and 10 ms.
module quadrature_speed_odometer_top #(
  parameter int COUNT_BITS = qso_pkg::COUNT_BITS_DEF,
  parameter int SPEED_BITS = qso_pkg::SPEED_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  qso_in_if.sink    in_ch,
  qso_out_if.source out_ch,
  qso_cfg_if.sink   cfg_ch
);

  qso_pkg::top_state_t state_r, state_nxt;

  logic [31:0]           dpp_r;
  logic [15:0]           period_r;
  logic [COUNT_BITS-1:0] pulse_count_r;
  logic [COUNT_BITS-1:0] count_at_last_tick_r;
  logic [SPEED_BITS-1:0] held_speed_r;
  logic [31:0]           held_velocity_r;
  logic [63:0]           travel_total_r;
  logic                  sat_r;
  logic                  neg_r;
  logic                  out_valid_r;

  logic signed [31:0] out_position_r;
  logic signed [15:0] out_pulse_speed_r;
  logic signed [31:0] out_velocity_r;
  logic               out_sat_r;
  logic signed [63:0] out_distance_r;

  logic                  in_rdy;
  logic                  in_xfer;
  logic                  start;
  logic                  load_out;
  qso_pkg::func_t        func;
  logic [SPEED_BITS-1:0] speed;
  logic                  speed_neg;
  logic [SPEED_BITS-1:0] mag;
  logic [15:0]           period_eff;
  logic [SPEED_BITS+31:0] step;
  qso_pkg::tick_res_t    res;

  assign func      = qso_pkg::func_t'(in_ch.func);
  assign in_xfer   = in_rdy & in_ch.valid;
  assign speed     = pulse_count_r[SPEED_BITS-1:0] - count_at_last_tick_r[SPEED_BITS-1:0];
  assign speed_neg = speed[SPEED_BITS-1];
  assign mag       = speed_neg ? (SPEED_BITS'(0) - speed) : speed;
  assign period_eff = (period_r == 16'd0) ? 16'd1 : period_r;

  assign in_ch.ready  = in_rdy;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid              = out_valid_r;
  assign out_ch.position           = out_position_r;
  assign out_ch.pulse_speed        = out_pulse_speed_r;
  assign out_ch.velocity           = out_velocity_r;
  assign out_ch.velocity_saturated = out_sat_r;
  assign out_ch.distance           = out_distance_r;

  qso_speed_unit #(
    .SPEED_BITS(SPEED_BITS)
  ) u_speed (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .neg             (speed_neg),
    .mag             (mag),
    .travel_per_count(dpp_r),
    .period          (period_eff),
    .step            (step),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qso_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_rdy    = 1'b0;
    start     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      qso_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          if (func == qso_pkg::FN_TICK) begin
            start     = 1'b1;
            state_nxt = qso_pkg::ST_WAIT;
          end else begin
            state_nxt = qso_pkg::ST_PUT;
          end
        end
      end
      qso_pkg::ST_WAIT: begin
        if (res.done) state_nxt = qso_pkg::ST_PUT;
      end
      qso_pkg::ST_PUT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = qso_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qso_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpp_r    <= '0;
      period_r <= qso_pkg::PERIOD_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == qso_pkg::CFG_TRAVEL_PER_COUNT) dpp_r <= cfg_ch.data[31:0];
      if (cfg_ch.index == qso_pkg::CFG_SAMPLE_PERIOD_MS) period_r <= cfg_ch.data[15:0];
    end
  end

  // odometer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_count_r        <= '0;
      count_at_last_tick_r <= '0;
      held_speed_r         <= '0;
      held_velocity_r      <= '0;
      travel_total_r       <= '0;
      sat_r                <= 1'b0;
      neg_r                <= 1'b0;
    end else if (in_xfer) begin
      sat_r <= 1'b0;
      case (func)
        qso_pkg::FN_EDGE: begin
          if (in_ch.phase_a == in_ch.phase_b) pulse_count_r <= pulse_count_r + 1'b1;
          else pulse_count_r <= pulse_count_r - 1'b1;
        end
        qso_pkg::FN_TICK: begin
          held_speed_r         <= speed;
          count_at_last_tick_r <= pulse_count_r;
          neg_r                <= speed_neg;
        end
        qso_pkg::FN_CLEAR: begin
          pulse_count_r        <= '0;
          count_at_last_tick_r <= '0;
          held_speed_r         <= '0;
          held_velocity_r      <= '0;
          travel_total_r       <= '0;
        end
        qso_pkg::FN_NONE: ;
        default: ;
      endcase
    end else if (state_r == qso_pkg::ST_WAIT && res.done) begin
      held_velocity_r <= res.velocity;
      sat_r           <= res.sat;
      travel_total_r  <= neg_r ? (travel_total_r - 64'(step)) : (travel_total_r + 64'(step));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_position_r    <= 32'($signed(pulse_count_r));
      out_pulse_speed_r <= 16'($signed(held_speed_r));
      out_velocity_r    <= held_velocity_r;
      out_sat_r         <= sat_r;
      out_distance_r    <= travel_total_r;
    end
  end

endmodule

// ----- sv/qso_speed_unit.sv -----
// Bit-serial multiply and divide unit for velocity and travel step of one sample tick.
module qso_speed_unit #(
  parameter int SPEED_BITS = qso_pkg::SPEED_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   neg,
  input  logic [SPEED_BITS-1:0]  mag,
  input  logic [31:0]            travel_per_count,
  input  logic [15:0]            period,
  output logic [SPEED_BITS+31:0] step,
  output qso_pkg::tick_res_t     res
);

  localparam int MB  = SPEED_BITS + qso_pkg::MS_BITS;
  localparam int PW  = 32 + MB;
  localparam int HIW = PW - 48;

  qso_pkg::unit_state_t state_r, state_nxt;
  logic [qso_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [SPEED_BITS-1:0] mag_r;
  logic                  neg_r;
  logic [31:0]           dpp_r;
  logic [15:0]           period_r;
  logic [31:0]           ma_hi_r, mb_hi_r;
  logic [MB-1:0]         ma_lo_r, mb_lo_r;
  logic                  over_r;
  logic [15:0]           rem_r;
  logic [31:0]           dq_r;

  logic [32:0]    suma, sumb;
  logic [PW-1:0]  prod;
  logic [HIW-1:0] prod_hi;
  logic [16:0]    trial;
  logic [16:0]    trial_diff;
  logic           ge;
  logic           sat;
  logic [31:0]    mvel;

  assign suma = {1'b0, ma_hi_r} + {1'b0, (ma_lo_r[0] ? dpp_r : 32'd0)};
  assign sumb = {1'b0, mb_hi_r} + {1'b0, (mb_lo_r[0] ? dpp_r : 32'd0)};

  // quotient by period << 16 is quotient of (prod >> 16) by period
  assign prod    = {mb_hi_r, mb_lo_r};
  assign prod_hi = prod[PW-1:48];

  assign trial      = {rem_r, dq_r[31]};
  assign trial_diff = trial - {1'b0, period_r};
  assign ge         = (trial >= {1'b0, period_r});

  always_comb begin
    if (!neg_r) begin
      sat  = over_r | dq_r[31];
      mvel = sat ? 32'h7FFF_FFFF : dq_r;
    end else begin
      sat  = over_r | (dq_r[31] & (|dq_r[30:0]));
      mvel = sat ? 32'h8000_0000 : dq_r;
    end
  end

  assign res.done     = (state_r == qso_pkg::U_DONE);
  assign res.sat      = sat;
  assign res.velocity = neg_r ? (32'd0 - mvel) : mvel;
  assign step         = {ma_hi_r[31-qso_pkg::MS_BITS:0], ma_lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qso_pkg::U_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      qso_pkg::U_IDLE: begin
        if (start) state_nxt = qso_pkg::U_PREP;
      end
      qso_pkg::U_PREP: begin
        cnt_nxt   = '0;
        state_nxt = qso_pkg::U_MUL;
      end
      qso_pkg::U_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == qso_pkg::CNT_W'(MB - 1)) state_nxt = qso_pkg::U_DSET;
      end
      qso_pkg::U_DSET: begin
        cnt_nxt   = '0;
        state_nxt = qso_pkg::U_DIV;
      end
      qso_pkg::U_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == qso_pkg::CNT_W'(qso_pkg::DIV_STEPS - 1)) state_nxt = qso_pkg::U_DONE;
      end
      qso_pkg::U_DONE: begin
        state_nxt = qso_pkg::U_IDLE;
      end
      default: state_nxt = qso_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      qso_pkg::U_IDLE: begin
        if (start) begin
          mag_r    <= mag;
          neg_r    <= neg;
          dpp_r    <= travel_per_count;
          period_r <= period;
        end
      end
      qso_pkg::U_PREP: begin
        ma_hi_r <= '0;
        mb_hi_r <= '0;
        ma_lo_r <= MB'(mag_r);
        mb_lo_r <= MB'(MB'(mag_r) * MB'(qso_pkg::MS_PER_S));
      end
      qso_pkg::U_MUL: begin
        ma_hi_r <= suma[32:1];
        ma_lo_r <= {suma[0], ma_lo_r[MB-1:1]};
        mb_hi_r <= sumb[32:1];
        mb_lo_r <= {sumb[0], mb_lo_r[MB-1:1]};
      end
      qso_pkg::U_DSET: begin
        over_r <= (16'(prod_hi) >= period_r);
        rem_r  <= 16'(prod_hi);
        dq_r   <= prod[47:16];
      end
      qso_pkg::U_DIV: begin
        rem_r <= ge ? trial_diff[15:0] : trial[15:0];
        dq_r  <= {dq_r[30:0], ge};
      end
      default: ;
    endcase
  end

endmodule
